// ===== hdl/hba_pkg.sv =====
// Package with the shared types, constants and codes of the heap block allocator.
`default_nettype none
package hba_pkg;
  localparam int unsigned HeapBytes   = 65536;
  localparam int unsigned MaxBlocks   = 16;
  localparam int unsigned HeaderBytes = 40;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned IdxW        = $clog2(MaxBlocks);
  localparam int unsigned CntW        = $clog2(MaxBlocks + 1);

  localparam logic [2:0] StReused   = 3'd0;
  localparam logic [2:0] StExtended = 3'd1;
  localparam logic [2:0] StZero     = 3'd2;
  localparam logic [2:0] StNoSpace  = 3'd3;
  localparam logic [2:0] StReleased = 3'd4;
  localparam logic [2:0] StInvalid  = 3'd5;

  localparam logic       FuncAlloc   = 1'b0;
  localparam logic [1:0] FitNext     = 2'd1;
  localparam logic [1:0] FitBest     = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] request_bytes;
    logic [1:0]  fit_mode;
    logic [15:0] release_addr;
  } hba_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] address;
  } hba_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_SCAN_END, S_SHIFT_UP, S_PLACE, S_REL_PREV,
    S_REL_NEXT, S_SHIFT_DOWN, S_DONE
  } hba_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;      // latch request, clear scan
    logic scan_step;  // examine entry at scan pointer
    logic scan_end;   // resolve the search
    logic shift_up;   // move one entry up for an insert
    logic place;      // apply allocation outcome
    logic rel_prev;   // merge with previous
    logic rel_next;   // merge next or trim tail
    logic shift_down; // move one entry down, or close the removal when done
    logic finish;     // load the result register
  } hba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic immediate;  // zero size: no search needed
    logic scan_last;  // scan pointer at last entry or search settled
    logic need_up;    // insert still needs shifting
    logic need_down;  // removal still needs shifting
    logic is_alloc;
    logic hit;        // release found its entry
    logic rel_done;   // merge with the next entry or tail trim already decided
  } hba_sts_t;
endpackage
`default_nettype wire

// ===== hdl/hba_ctrl.sv =====
// Controller state machine of the heap block allocator.
`default_nettype none
module hba_ctrl import hba_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     out_busy_i,
  input  wire hba_sts_t sts_i,
  output hba_cmd_t      cmd_o
);
  hba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE:     state_d = sts_i.immediate ? S_DONE : S_SCAN;
      S_SCAN:       if (sts_i.scan_last) state_d = S_SCAN_END;
      S_SCAN_END:   state_d = sts_i.is_alloc ? S_SHIFT_UP
                              : (sts_i.hit ? S_REL_PREV : S_DONE);
      S_SHIFT_UP:   if (!sts_i.need_up) state_d = S_PLACE;
      S_PLACE:      state_d = S_DONE;
      S_REL_PREV:   state_d = S_SHIFT_DOWN;
      S_SHIFT_DOWN: if (!sts_i.need_down) state_d = sts_i.rel_done ? S_DONE : S_REL_NEXT;
      S_REL_NEXT:   state_d = S_SHIFT_DOWN;
      S_DONE:       if (!out_busy_i) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.start = in_valid_i;
      end
      S_SCAN:       cmd_o.scan_step = 1'b1;
      S_SCAN_END:   cmd_o.scan_end = 1'b1;
      S_SHIFT_UP:   cmd_o.shift_up = sts_i.need_up;
      S_PLACE:      cmd_o.place = 1'b1;
      S_REL_PREV:   cmd_o.rel_prev = 1'b1;
      S_SHIFT_DOWN: cmd_o.shift_down = 1'b1;
      S_REL_NEXT:   cmd_o.rel_next = 1'b1;
      S_DONE:       cmd_o.finish = !out_busy_i;
      default:      cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/hba_dp.sv =====
// Datapath of the heap block allocator: block table, search and updates.
`default_nettype none
module hba_dp import hba_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire hba_in_t     in_i,
  input  wire logic [16:0] limit_i,
  input  wire hba_cmd_t    cmd_i,
  output hba_sts_t         sts_o,
  output hba_out_t         res_o
);
  localparam logic [16:0] Hdr17   = 17'(HeaderBytes);
  localparam logic [16:0] Split17 = 17'(HeaderBytes + AlignBytes);
  localparam logic [16:0] Heap17  = 17'(HeapBytes);

  logic [15:0] st_q [MaxBlocks];
  logic [15:0] sz_q [MaxBlocks];
  logic        fr_q [MaxBlocks];
  logic [CntW-1:0] cnt_q;
  logic [16:0] top_q;
  logic [CntW-1:0] rov_q;

  hba_in_t     req_q;
  logic [16:0] size_q;        // rounded request
  logic [CntW-1:0] scan_q;    // entries examined
  logic [IdxW-1:0] ptr_q;     // current entry
  logic        found_q;
  logic [IdxW-1:0] sel_q;     // chosen entry
  logic        ins_q;         // insert pending
  logic [CntW-1:0] mv_q;      // shift pointer
  logic [CntW-1:0] rm_q;      // entry being removed
  logic        rm_pend_q;     // a removal is in progress
  logic        rm_tail_q;
  logic [2:0]  status_q;
  logic [15:0] addr_q;        // granted address, held until the result is loaded

  // Scan view of the current entry.
  logic [15:0] cur_st, cur_sz;
  logic        cur_fr, cur_fit, cur_rel;
  assign cur_st  = st_q[ptr_q];
  assign cur_sz  = sz_q[ptr_q];
  assign cur_fr  = fr_q[ptr_q];
  assign cur_fit = cur_fr && ({1'b0, cur_sz} >= size_q);
  assign cur_rel = !cur_fr && ((17'(cur_st) + Hdr17) == {1'b0, req_q.release_addr});

  logic is_best;
  assign is_best = (req_q.fit_mode == FitBest);
  logic settle;
  assign settle = (req_q.func == FuncAlloc) ? (cur_fit && !is_best) : cur_rel;

  logic [CntW-1:0] cnt_m1, next_scan;
  assign cnt_m1    = cnt_q - CntW'(1);
  assign next_scan = scan_q + CntW'(1);

  logic [IdxW-1:0] ptr_inc;
  assign ptr_inc = (CntW'(ptr_q) + CntW'(1) >= cnt_q) ? '0 : ptr_q + IdxW'(1);

  logic [16:0] sel_sz, rem;
  assign sel_sz = {1'b0, sz_q[sel_q]};
  assign rem    = sel_sz - size_q;

  logic [16:0] limit;
  assign limit = (limit_i < Heap17) ? limit_i : Heap17;

  // One bit wider than the heap top so a large request near the limit cannot wrap.
  logic [17:0] top_need;
  assign top_need = 18'(top_q) + 18'(Hdr17) + 18'(size_q);

  logic need_down;
  assign need_down = rm_pend_q && (mv_q + CntW'(1) < cnt_q);

  assign sts_o.immediate = (req_q.func == FuncAlloc) && (req_q.request_bytes == '0);
  assign sts_o.scan_last = (cnt_q == '0) || (next_scan >= cnt_q) || (cmd_i.scan_step && settle);
  assign sts_o.need_up   = ins_q && (mv_q > (CntW'(sel_q) + CntW'(1)));
  assign sts_o.need_down = need_down;
  assign sts_o.is_alloc  = (req_q.func == FuncAlloc) && (size_q != '0);
  assign sts_o.hit       = found_q;
  assign sts_o.rel_done  = rm_tail_q;

  logic [IdxW-1:0] mvi;
  assign mvi = mv_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      top_q <= '0;
      rov_q <= '0;
      found_q <= 1'b0;
      ins_q <= 1'b0;
      rm_q <= '0;
      rm_pend_q <= 1'b0;
      rm_tail_q <= 1'b0;
      status_q <= StZero;
      res_o <= '0;
    end else begin
      if (cmd_i.start) begin
        req_q   <= in_i;
        size_q  <= (17'(in_i.request_bytes) + 17'(AlignBytes - 1)) &
                   ~17'(AlignBytes - 1);
        scan_q  <= '0;
        found_q <= 1'b0;
        ins_q   <= 1'b0;
        rm_q    <= '0;
        rm_pend_q <= 1'b0;
        rm_tail_q <= 1'b0;
        if (in_i.func == FuncAlloc && in_i.fit_mode == FitNext && rov_q < cnt_q)
          ptr_q <= rov_q[IdxW-1:0];
        else
          ptr_q <= '0;
        status_q <= (in_i.func == FuncAlloc && in_i.request_bytes == '0) ? StZero : StNoSpace;
      end
      if (cmd_i.scan_step && cnt_q != '0 && !(found_q && !is_best)) begin
        scan_q <= next_scan;
        ptr_q  <= ptr_inc;
        if (req_q.func == FuncAlloc) begin
          if (cur_fit && (!found_q || cur_sz < sz_q[sel_q])) begin
            found_q <= 1'b1;
            sel_q   <= ptr_q;
          end
        end else if (cur_rel && !found_q) begin
          found_q <= 1'b1;
          sel_q   <= ptr_q;
        end
      end
      if (cmd_i.scan_end) begin
        mv_q <= cnt_q;
        if (req_q.func == FuncAlloc) begin
          if (found_q) begin
            status_q <= StReused;
            if (req_q.fit_mode == FitNext) rov_q <= CntW'(sel_q);
            ins_q <= (rem >= Split17) && (cnt_q < CntW'(MaxBlocks));
          end else if (cnt_q < CntW'(MaxBlocks) && top_need <= {1'b0, limit}) begin
            status_q <= StExtended;
          end
        end else begin
          status_q <= found_q ? StReleased : StInvalid;
          if (found_q) fr_q[sel_q] <= 1'b1;
        end
      end
      if (cmd_i.shift_up) begin
        st_q[mvi] <= st_q[mvi - IdxW'(1)];
        sz_q[mvi] <= sz_q[mvi - IdxW'(1)];
        fr_q[mvi] <= fr_q[mvi - IdxW'(1)];
        mv_q <= mv_q - CntW'(1);
      end
      if (cmd_i.place) begin
        if (status_q == StReused) begin
          fr_q[sel_q] <= 1'b0;
          addr_q <= 16'(17'(st_q[sel_q]) + Hdr17);
          if (ins_q) begin
            sz_q[sel_q] <= size_q[15:0];
            st_q[sel_q + IdxW'(1)] <= 16'(17'(st_q[sel_q]) + Hdr17 + size_q);
            sz_q[sel_q + IdxW'(1)] <= 16'(rem - Hdr17);
            fr_q[sel_q + IdxW'(1)] <= 1'b1;
            cnt_q <= cnt_q + CntW'(1);
            if (rov_q > CntW'(sel_q) && rov_q + CntW'(1) < cnt_q + CntW'(1))
              rov_q <= rov_q + CntW'(1);
          end
        end else if (status_q == StExtended) begin
          st_q[cnt_q[IdxW-1:0]] <= top_q[15:0];
          sz_q[cnt_q[IdxW-1:0]] <= size_q[15:0];
          fr_q[cnt_q[IdxW-1:0]] <= 1'b0;
          cnt_q <= cnt_q + CntW'(1);
          top_q <= top_need[16:0];
          addr_q <= 16'(top_q + Hdr17);
        end
      end
      // Merge with previous: grow previous, remove sel.
      if (cmd_i.rel_prev) begin
        if (sel_q != '0 && fr_q[sel_q - IdxW'(1)]) begin
          sz_q[sel_q - IdxW'(1)] <= 16'(17'(sz_q[sel_q - IdxW'(1)]) + Hdr17 +
                                        17'(sz_q[sel_q]));
          rm_q <= CntW'(sel_q);
          mv_q <= CntW'(sel_q);
          rm_pend_q <= 1'b1;
          sel_q <= sel_q - IdxW'(1);
        end else begin
          rm_pend_q <= 1'b0;
        end
      end
      // Shift the entries above a removed one down, then fix count and rover.
      if (cmd_i.shift_down) begin
        if (need_down) begin
          st_q[mvi] <= st_q[mvi + IdxW'(1)];
          sz_q[mvi] <= sz_q[mvi + IdxW'(1)];
          fr_q[mvi] <= fr_q[mvi + IdxW'(1)];
          mv_q <= mv_q + CntW'(1);
        end else if (rm_pend_q) begin
          cnt_q <= cnt_m1;
          if (rov_q > rm_q) rov_q <= (rov_q - CntW'(1) >= cnt_m1) ? '0 : rov_q - CntW'(1);
          else if (rov_q == rm_q) rov_q <= (rm_q - CntW'(1) >= cnt_m1) ? '0 : rm_q - CntW'(1);
          else if (rov_q >= cnt_m1) rov_q <= '0;
          rm_pend_q <= 1'b0;
        end
      end
      // Merge with the next entry, or give a freed tail back to the heap top.
      if (cmd_i.rel_next) begin
        rm_tail_q <= 1'b1;
        if (CntW'(sel_q) + CntW'(1) < cnt_q) begin
          if (fr_q[sel_q + IdxW'(1)]) begin
            sz_q[sel_q] <= 16'(17'(sz_q[sel_q]) + Hdr17 + 17'(sz_q[sel_q + IdxW'(1)]));
            rm_q <= CntW'(sel_q) + CntW'(1);
            mv_q <= CntW'(sel_q) + CntW'(1);
            rm_pend_q <= 1'b1;
          end
        end else begin
          top_q <= {1'b0, st_q[sel_q]};
          rm_q  <= CntW'(sel_q);
          mv_q  <= CntW'(sel_q);
          rm_pend_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        res_o.status  <= status_q;
        res_o.address <= (status_q == StReused || status_q == StExtended) ? addr_q : '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/heap_block_allocator.sv =====
// Top level of the heap block allocator: ports, limit register and output stage.
//
//  Channel  | Direction | Handshake           | Payload
//  in       | in        | in_valid_i/in_stall_o | hba_in_t
//  out      | out       | out_valid_o/out_stall_i | hba_out_t
//  cfg      | in        | cfg_valid_i/cfg_ready_o | 17-bit heap limit
//
// One transfer is handled at a time; a new input transfer is taken only once the
// last one has passed its result to the output register.
// The search walks the block table one entry a cycle, and each insert or
// removal moves one table entry a cycle.
// Reset empties the table, the heap top and the rover; the limit resets to 65536.
// An input transfer may be taken while a result waits on a stalled output; that
// item then holds in its last state until the output is no longer stalled.
`default_nettype none
module heap_block_allocator import hba_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire hba_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output hba_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [16:0] cfg_data_i
);
  logic [16:0] limit_q;
  logic        ovalid_q;
  hba_cmd_t    cmd;
  hba_sts_t    sts;
  hba_out_t    res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 17'(HeapBytes);
    else if (cfg_valid_i) limit_q <= cfg_data_i;
  end

  // The result register is held valid until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.finish) ovalid_q <= 1'b1;
    else if (!out_stall_i) ovalid_q <= 1'b0;
  end
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res;

  hba_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(ovalid_q && out_stall_i), .sts_i(sts), .cmd_o(cmd)
  );

  hba_dp u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .limit_i(limit_q),
    .cmd_i(cmd), .sts_o(sts), .res_o(res)
  );

  a_one_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o) else $error("result not presented");
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped while stalled");
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("result changed");
endmodule
`default_nettype wire

// ===== sim/tb_heap_block_allocator.sv =====
// Self-checking testbench for the heap block allocator, with an in-bench predictor.
`default_nettype none
module tb_heap_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import hba_pkg::*;

  // The package names only some of the codes, so the rest are named here.
  localparam logic       FuncRelease = 1'b1;
  localparam logic [1:0] FitFirst    = 2'd0;
  localparam logic [1:0] FitSpare    = 2'd3;

  // Clock and reset. Inputs move on the falling edge and outputs are sampled
  // on the rising edge, so nothing depends on event order within a step.
  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  hba_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  hba_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i = '0;

  heap_block_allocator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the allocator: block table, heap top, rover and limit.
  logic [15:0] blk_start [MaxBlocks];
  logic [15:0] blk_size [MaxBlocks];
  bit          blk_free [MaxBlocks];
  int unsigned blk_count;
  int unsigned heap_top;
  int unsigned rover;
  int unsigned heap_limit;

  hba_out_t grant_queue[$];   // expected results in order
  int       fail_count = 0;
  bit       quiet = 1'b0;     // when set, neither side idles
  int       cycle_count = 0;
  int       hold_until = 0;   // the receiver stalls while cycle_count is below this

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void put_blk(int unsigned k, int unsigned st, int unsigned sz, bit fr);
    blk_start[k] = st[15:0];
    blk_size[k]  = sz[15:0];
    blk_free[k]  = fr;
  endfunction

  function automatic void insert_blk(int unsigned j, int unsigned st, int unsigned sz, bit fr);
    for (int unsigned k = blk_count; k > j; k--)
      put_blk(k, blk_start[k-1], blk_size[k-1], blk_free[k-1]);
    put_blk(j, st, sz, fr);
    blk_count++;
    // The rover keeps following its block as the entries above it move up.
    if (rover >= j && rover + 1 < blk_count && rover != j - 1) rover++;
  endfunction

  function automatic void remove_blk(int unsigned j);
    for (int unsigned k = j; k + 1 < blk_count; k++)
      put_blk(k, blk_start[k+1], blk_size[k+1], blk_free[k+1]);
    blk_count--;
    if (rover > j) rover--;
    else if (rover == j) rover = (j > 0) ? j - 1 : 0;
    if (rover >= blk_count) rover = 0;
  endfunction

  function automatic void merge_blk(int unsigned j);
    blk_size[j] = 16'(blk_size[j] + HeaderBytes + blk_size[j+1]);
    remove_blk(j + 1);
  endfunction

  function automatic int search_fit(logic [1:0] mode, int unsigned s);
    int best;
    int unsigned k;
    int unsigned first;
    best = -1;
    if (mode == FitNext) begin
      // Next fit starts at the rover entry itself and wraps once round.
      first = (rover < blk_count) ? rover : 0;
      for (int unsigned n = 0; n < blk_count; n++) begin
        k = first + n;
        if (k >= blk_count) k -= blk_count;
        if (blk_free[k] && blk_size[k] >= s) begin
          rover = k;
          return k;
        end
      end
      return -1;
    end
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= s) begin
        if (mode != FitBest) return i;
        // Strictly smaller wins, so a tie keeps the lower address.
        if (best < 0 || blk_size[i] < blk_size[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic hba_out_t predict_grant(hba_in_t req);
    hba_out_t    res;
    logic [1:0]  mode;
    int unsigned s;
    int unsigned lim;
    int          hit;
    int unsigned j;
    res = '0;
    mode = (req.fit_mode == FitSpare) ? FitFirst : req.fit_mode;
    if (req.func == FuncAlloc) begin
      if (req.request_bytes == 0) begin
        res.status = StZero;
        return res;
      end
      s = ((req.request_bytes + AlignBytes - 1) / AlignBytes) * AlignBytes;
      hit = search_fit(mode, s);
      if (hit >= 0) begin
        j = hit;
        // Split only when the remainder holds a header and one aligned unit.
        if (blk_size[j] - s >= HeaderBytes + AlignBytes && blk_count < MaxBlocks) begin
          insert_blk(j + 1, blk_start[j] + HeaderBytes + s, blk_size[j] - s - HeaderBytes, 1'b1);
          blk_size[j] = s[15:0];
        end
        blk_free[j] = 1'b0;
        res.status  = StReused;
        res.address = 16'(blk_start[j] + HeaderBytes);
        return res;
      end
      lim = (heap_limit < HeapBytes) ? heap_limit : HeapBytes;
      if (blk_count >= MaxBlocks || heap_top + HeaderBytes + s > lim) begin
        res.status = StNoSpace;
        return res;
      end
      put_blk(blk_count, heap_top, s, 1'b0);
      blk_count++;
      res.status  = StExtended;
      res.address = 16'(heap_top + HeaderBytes);
      heap_top += HeaderBytes + s;
      return res;
    end
    hit = -1;
    for (int unsigned k = 0; k < blk_count; k++) begin
      if (blk_start[k] + HeaderBytes == req.release_addr && !blk_free[k]) begin
        hit = k;
        break;
      end
    end
    if (hit < 0) begin
      res.status = StInvalid;
      return res;
    end
    j = hit;
    blk_free[j] = 1'b1;
    if (j > 0 && blk_free[j-1]) begin
      merge_blk(j - 1);
      j--;
    end
    if (j + 1 < blk_count) begin
      if (blk_free[j+1]) merge_blk(j);
    end else begin
      // A freed tail goes back to the heap top.
      heap_top = blk_start[j];
      remove_blk(j);
    end
    res.status = StReleased;
    return res;
  endfunction

  // Receiver: random stalls, none in quiet stretches, a solid stall during a hold-off.
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count < hold_until) out_stall_i <= 1'b1;
    else if (quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 24);
  end

  // Result checker: every output transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_queue.size() == 0) begin
        report_mismatch("unexpected result, status", out_data_o.status, -1);
      end else begin
        if (out_data_o.status !== grant_queue[0].status)
          report_mismatch("status", out_data_o.status, grant_queue[0].status);
        if (out_data_o.address !== grant_queue[0].address)
          report_mismatch("address", out_data_o.address, grant_queue[0].address);
        void'(grant_queue.pop_front());
      end
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  // Valid stays high into the next call unless that call idles first.
  task automatic send_request(input hba_in_t req);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 24) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid_i = 1'b1;
    in_data_i  = req;
    do @(posedge clk); while (in_stall_o);
    grant_queue.push_back(predict_grant(req));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid_i = 1'b0;
  endtask

  // Waits until every expected result is in, then lets the block settle.
  task automatic drain();
    stop_sending();
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(input int unsigned value);
    drain();
    @(negedge clk);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value[16:0];
    do @(posedge clk); while (!cfg_ready_o);
    heap_limit = value & 32'h1FFFF;
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  function automatic hba_in_t alloc_req(int unsigned bytes, logic [1:0] mode);
    hba_in_t r;
    r = '0;
    r.func = FuncAlloc;
    r.request_bytes = bytes[15:0];
    r.fit_mode = mode;
    r.release_addr = 16'($urandom);
    return r;
  endfunction

  function automatic hba_in_t release_req(int unsigned addr);
    hba_in_t r;
    r = '0;
    r.func = FuncRelease;
    r.request_bytes = 16'($urandom);
    r.fit_mode = 2'($urandom_range(3));
    r.release_addr = addr[15:0];
    return r;
  endfunction

  // Mostly well-formed traffic: small sizes and releases of live blocks,
  // with some oversized requests, stale releases and random addresses.
  function automatic hba_in_t random_req();
    int unsigned pick;
    int unsigned live [$];
    int unsigned dead [$];
    int unsigned sz;
    pick = $urandom_range(99);
    if (blk_count == 0 || pick < 55) begin
      pick = $urandom_range(99);
      if (pick < 80) sz = $urandom_range(200, 1);
      else if (pick < 90) sz = $urandom_range(2000, 201);
      else if (pick < 95) sz = $urandom_range(65535);
      else sz = 0;
      return alloc_req(sz, 2'($urandom_range(3)));
    end
    for (int unsigned k = 0; k < blk_count; k++) begin
      if (blk_free[k]) dead.push_back(blk_start[k] + HeaderBytes);
      else live.push_back(blk_start[k] + HeaderBytes);
    end
    pick = $urandom_range(99);
    if (pick < 75 && live.size() > 0) return release_req(live[$urandom_range(live.size() - 1)]);
    if (pick < 88 && dead.size() > 0) return release_req(dead[$urandom_range(dead.size() - 1)]);
    return release_req($urandom_range(65535));
  endfunction

  task automatic test_directed();
    send_request(alloc_req(0, FitFirst));          // zero size is refused
    send_request(release_req(HeaderBytes));        // release on an empty heap
    send_request(alloc_req(65535, FitBest));       // larger than the heap
    send_request(alloc_req(1, FitSpare));          // mode three acts as first fit
    send_request(alloc_req(100, FitFirst));
    send_request(alloc_req(24, FitNext));
    send_request(alloc_req(200, FitBest));
    send_request(alloc_req(64, FitFirst));
    send_request(release_req(HeaderBytes + 8 + HeaderBytes));   // middle block
    send_request(release_req(HeaderBytes + 8 + HeaderBytes));   // already free
    send_request(release_req(HeaderBytes));        // merges with its free neighbor
    send_request(alloc_req(8, FitBest));           // reuse with a split
    send_request(alloc_req(16, FitNext));          // next fit from the rover
    send_request(alloc_req(500, FitNext));
    send_request(release_req(16'hFFFF));
    send_request(release_req(16'h0000));
    send_request(release_req(blk_start[blk_count-1] + HeaderBytes));  // tail trim
    send_request(alloc_req(16'h8000, FitFirst));
    send_request(alloc_req(16'h7FFF, FitFirst));
    drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_request(random_req());
    drain();
  endtask

  // The receiver holds off while the sender keeps offering, so the block fills up.
  task automatic test_backpressure();
    hold_until = cycle_count + 600;
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) send_request(random_req());
    quiet = 1'b0;
    drain();
  endtask

  // Free every block so the heap collapses back to empty.
  task automatic test_release_all();
    while (blk_count != 0) begin
      int unsigned addr;
      addr = 0;
      for (int unsigned k = 0; k < blk_count; k++)
        if (!blk_free[k]) addr = blk_start[k] + HeaderBytes;
      if (addr == 0) break;
      send_request(release_req(addr));
    end
    drain();
  endtask

  initial begin
    for (int k = 0; k < MaxBlocks; k++) put_blk(k, 0, 0, 1'b0);
    blk_count = 0;
    heap_top = 0;
    rover = 0;
    heap_limit = 65536;
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;
    test_directed();
    test_random(300);
    quiet = 1'b1;
    test_random(200);
    quiet = 1'b0;
    write_limit(0);
    test_random(100);
    write_limit(131071);
    test_backpressure();
    test_random(250);
    write_limit(1200);
    test_random(250);
    test_release_all();
    write_limit(600);
    test_random(200);
    write_limit(65536);
    test_random(300);
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
